FILE: hdl/ttf_pkg.sv
// ----------------------------------------------------------------------------
// ttf_pkg
// Shared widths, status codes and word types of the triangle tangent frame.
// ----------------------------------------------------------------------------
package ttf_pkg;

  localparam int COORD_W  = 24;
  localparam int UV_W     = 20;
  localparam int NORM_W   = 16;
  localparam int UNIT_W   = 16;
  localparam int THR_W    = 15;
  localparam int STATUS_W = 2;

  localparam logic [THR_W-1:0] THR_RESET = 15'd16220;
  localparam logic signed [UNIT_W-1:0] UNIT_ONE = 16'sd16384;

  // edge and uv delta widths, shared multiplier and accumulator widths
  localparam int E_W     = COORD_W + 1;
  localparam int DUV_W   = UV_W + 1;
  localparam int MUL_A_W = (E_W > DUV_W) ? E_W : DUV_W;
  localparam int PROD_W  = MUL_A_W + DUV_W;
  localparam int VEC_W   = PROD_W + 1;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [STATUS_W-1:0] ST_NORMAL   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FALLBACK = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO     = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [UV_W-1:0]    tex_u;
    logic signed [UV_W-1:0]    tex_v;
    logic signed [NORM_W-1:0]  norm_x;
    logic signed [NORM_W-1:0]  norm_y;
    logic signed [NORM_W-1:0]  norm_z;
  } vertex_t;

  typedef struct packed {
    logic signed [UNIT_W-1:0] tan_x;
    logic signed [UNIT_W-1:0] tan_y;
    logic signed [UNIT_W-1:0] tan_z;
    logic signed [UNIT_W-1:0] bitan_x;
    logic signed [UNIT_W-1:0] bitan_y;
    logic signed [UNIT_W-1:0] bitan_z;
    logic [STATUS_W-1:0]      frame_status;
  } frame_t;

  typedef struct packed {
    logic signed [E_W-1:0]    e1x;
    logic signed [E_W-1:0]    e1y;
    logic signed [E_W-1:0]    e1z;
    logic signed [E_W-1:0]    e2x;
    logic signed [E_W-1:0]    e2y;
    logic signed [E_W-1:0]    e2z;
    logic signed [DUV_W-1:0]  du1;
    logic signed [DUV_W-1:0]  dv1;
    logic signed [DUV_W-1:0]  du2;
    logic signed [DUV_W-1:0]  dv2;
    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nz;
    logic [THR_W-1:0]         thr;
  } job_t;

  typedef struct packed {
    logic done;
    logic zero;
  } norm_stat_t;

endpackage

FILE: hdl/triangle_tangent_frame.sv
// ----------------------------------------------------------------------------
// triangle_tangent_frame
// Vertices one and two of a triangle are taken whenever offered; the third
// queues a job (two deep) and waits while the queue is full. Each job runs
// through the shared multiplier steps and the bit-serial square root and
// divider of the normalizer.
// Sync reset clears the vertex slot, queue, sequencers and sets the
// threshold to 16220; stored vertex data is undefined until written.
// ----------------------------------------------------------------------------
module triangle_tangent_frame import ttf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             thr_we,
  input  logic [THR_W-1:0] thr_data,
  input  logic             vtx_valid,
  output logic             vtx_ready,
  input  vertex_t          vtx,
  output logic             frame_valid,
  input  logic             frame_ready,
  output frame_t           frame
);

  logic push, full, job_valid, pop;
  job_t wr_job, rd_job;

  ttf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .thr_we    (thr_we),
    .thr_data  (thr_data),
    .vtx_valid (vtx_valid),
    .vtx_ready (vtx_ready),
    .vtx       (vtx),
    .push      (push),
    .job       (wr_job),
    .full      (full)
  );

  ttf_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .full   (full),
    .valid  (job_valid),
    .rd_job (rd_job),
    .pop    (pop)
  );

  ttf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (job_valid),
    .job_in      (rd_job),
    .pop         (pop),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame)
  );

endmodule

FILE: hdl/ttf_front.sv
// ----------------------------------------------------------------------------
// ttf_front
// Takes vertices, holds the first two and forms edges and uv deltas on the
// third, which is pushed as one job.
// ----------------------------------------------------------------------------
module ttf_front import ttf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             thr_we,
  input  logic [THR_W-1:0] thr_data,
  input  logic             vtx_valid,
  output logic             vtx_ready,
  input  vertex_t          vtx,
  output logic             push,
  output job_t             job,
  input  logic             full
);

  localparam logic [1:0] SLOT_FIRST  = 2'd0;
  localparam logic [1:0] SLOT_SECOND = 2'd1;
  localparam logic [1:0] SLOT_THIRD  = 2'd2;

  logic [1:0]               slot;
  logic [THR_W-1:0]         thr;
  vertex_t                  v0;
  logic signed [COORD_W-1:0] p1x, p1y, p1z;
  logic signed [UV_W-1:0]    u1, w1;
  logic                     take;

  assign vtx_ready = (slot != SLOT_THIRD) || !full;
  assign take      = vtx_valid && vtx_ready;
  assign push      = take && (slot == SLOT_THIRD);

  always_comb begin
    job.e1x = E_W'(p1x) - E_W'(v0.pos_x);
    job.e1y = E_W'(p1y) - E_W'(v0.pos_y);
    job.e1z = E_W'(p1z) - E_W'(v0.pos_z);
    job.e2x = E_W'(vtx.pos_x) - E_W'(v0.pos_x);
    job.e2y = E_W'(vtx.pos_y) - E_W'(v0.pos_y);
    job.e2z = E_W'(vtx.pos_z) - E_W'(v0.pos_z);
    job.du1 = DUV_W'(u1) - DUV_W'(v0.tex_u);
    job.dv1 = DUV_W'(w1) - DUV_W'(v0.tex_v);
    job.du2 = DUV_W'(vtx.tex_u) - DUV_W'(v0.tex_u);
    job.dv2 = DUV_W'(vtx.tex_v) - DUV_W'(v0.tex_v);
    job.nx  = v0.norm_x;
    job.ny  = v0.norm_y;
    job.nz  = v0.norm_z;
    job.thr = thr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= SLOT_FIRST;
      thr  <= THR_RESET;
    end else begin
      if (thr_we) begin
        thr <= thr_data;
      end
      if (take) begin
        case (slot)
          SLOT_SECOND: slot <= SLOT_THIRD;
          SLOT_THIRD:  slot <= SLOT_FIRST;
          default:     slot <= SLOT_SECOND;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      case (slot)
        SLOT_SECOND: begin
          p1x <= vtx.pos_x;
          p1y <= vtx.pos_y;
          p1z <= vtx.pos_z;
          u1  <= vtx.tex_u;
          w1  <= vtx.tex_v;
        end
        SLOT_THIRD: begin
        end
        default: begin
          v0 <= vtx;
        end
      endcase
    end
  end

endmodule

FILE: hdl/ttf_queue.sv
// ----------------------------------------------------------------------------
// ttf_queue
// Short job queue between the vertex front end and the frame back end.
// ----------------------------------------------------------------------------
module ttf_queue import ttf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wr_job,
  output logic full,
  output logic valid,
  output job_t rd_job,
  input  logic pop
);

  job_t                 mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wp, rp;
  logic [Q_CNT_W-1:0]   cnt;

  assign full   = (cnt == Q_CNT_W'(Q_DEPTH));
  assign valid  = (cnt != '0);
  assign rd_job = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

FILE: hdl/ttf_norm.sv
// ----------------------------------------------------------------------------
// ttf_norm
// Iterative vector normalizer: block shift, sum of squares, bit-pair square
// root and restoring divide, giving Q1.14 components.
// ----------------------------------------------------------------------------
module ttf_norm import ttf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [VEC_W-1:0]  cx,
  input  logic signed [VEC_W-1:0]  cy,
  input  logic signed [VEC_W-1:0]  cz,
  output norm_stat_t               stat,
  output logic signed [UNIT_W-1:0] ox,
  output logic signed [UNIT_W-1:0] oy,
  output logic signed [UNIT_W-1:0] oz
);

  localparam int DIV_W = 46;
  localparam int Q_W   = 15;

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_SHIFT = 3'd1;
  localparam logic [2:0] N_SQ    = 3'd2;
  localparam logic [2:0] N_SQRT  = 3'd3;
  localparam logic [2:0] N_DLOAD = 3'd4;
  localparam logic [2:0] N_DIV   = 3'd5;

  function automatic logic [VEC_W-1:0] mag(input logic signed [VEC_W-1:0] c);
    mag = c[VEC_W-1] ? VEC_W'(-c) : VEC_W'(c);
  endfunction

  logic [2:0]               state;
  logic [VEC_W-1:0]         m [3];
  logic                     sgn [3];
  logic [VEC_W-1:0]         mx;
  logic [1:0]               idx;
  logic                     ph;
  logic [59:0]              sq;
  logic [61:0]              sum;
  logic [63:0]              x, root, bit4, trial;
  logic [DIV_W-1:0]         rem, dsh;
  logic [Q_W-1:0]           q;
  logic [3:0]               cnt;
  logic                     ge;
  logic [Q_W-1:0]           qn;
  logic signed [UNIT_W-1:0] o [3];
  logic [VEC_W-1:0]         ma, mb, mc, mab;
  logic                     done, zero;

  assign ma    = mag(cx);
  assign mb    = mag(cy);
  assign mc    = mag(cz);
  assign mab   = (mb > ma) ? mb : ma;
  assign trial = root + bit4;
  assign ge    = (rem >= dsh);
  assign qn    = {q[Q_W-2:0], ge};

  assign ox        = o[0];
  assign oy        = o[1];
  assign oz        = o[2];
  assign stat.done = done;
  assign stat.zero = zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      done  <= 1'b0;
      zero  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        N_IDLE: begin
          if (start) begin
            m[0]   <= ma;
            m[1]   <= mb;
            m[2]   <= mc;
            sgn[0] <= cx[VEC_W-1];
            sgn[1] <= cy[VEC_W-1];
            sgn[2] <= cz[VEC_W-1];
            mx     <= (mc > mab) ? mc : mab;
            state  <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          // bring the largest magnitude into [2^29, 2^30)
          if (mx == '0) begin
            done  <= 1'b1;
            zero  <= 1'b1;
            state <= N_IDLE;
          end else if (|mx[VEC_W-1:38]) begin
            mx <= mx >> 8;
            for (int i = 0; i < 3; i++) m[i] <= m[i] >> 8;
          end else if (|mx[VEC_W-1:30]) begin
            mx <= mx >> 1;
            for (int i = 0; i < 3; i++) m[i] <= m[i] >> 1;
          end else if (!(|mx[VEC_W-1:21])) begin
            mx <= mx << 8;
            for (int i = 0; i < 3; i++) m[i] <= m[i] << 8;
          end else if (!mx[29]) begin
            mx <= mx << 1;
            for (int i = 0; i < 3; i++) m[i] <= m[i] << 1;
          end else begin
            idx   <= 2'd0;
            ph    <= 1'b0;
            sum   <= '0;
            state <= N_SQ;
          end
        end
        N_SQ: begin
          if (!ph) begin
            sq <= m[idx][29:0] * m[idx][29:0];
            ph <= 1'b1;
          end else begin
            ph  <= 1'b0;
            sum <= sum + 62'(sq);
            if (idx == 2'd2) begin
              x     <= 64'(sum + 62'(sq));
              root  <= '0;
              bit4  <= 64'd1 << 62;
              state <= N_SQRT;
            end else begin
              idx <= idx + 2'd1;
            end
          end
        end
        N_SQRT: begin
          if (x >= trial) begin
            x    <= x - trial;
            root <= (root >> 1) + bit4;
          end else begin
            root <= root >> 1;
          end
          bit4 <= bit4 >> 2;
          if (bit4[0]) begin
            idx   <= 2'd0;
            state <= N_DLOAD;
          end
        end
        N_DLOAD: begin
          // numerator m*2^15 + r over 2r, so the quotient rounds to nearest
          rem   <= DIV_W'({m[idx][29:0], 15'd0}) + DIV_W'(root);
          dsh   <= DIV_W'(root) << 15;
          q     <= '0;
          cnt   <= '0;
          state <= N_DIV;
        end
        N_DIV: begin
          if (ge) begin
            rem <= rem - dsh;
          end
          q   <= qn;
          dsh <= dsh >> 1;
          if (cnt == 4'(Q_W - 1)) begin
            o[idx] <= sgn[idx] ? -$signed({1'b0, qn}) : $signed({1'b0, qn});
            if (idx == 2'd2) begin
              done  <= 1'b1;
              zero  <= 1'b0;
              state <= N_IDLE;
            end else begin
              idx   <= idx + 2'd1;
              state <= N_DLOAD;
            end
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        default: state <= N_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == N_IDLE)
    else $error("normalizer started while busy");

  a_shift_window: assert property (@(posedge clk) disable iff (rst)
    (state == N_SQ && idx == 2'd0 && !ph) |-> (mx[29] && !(|mx[VEC_W-1:30])))
    else $error("block shift left largest magnitude outside window");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    (stat.done && !stat.zero) |=> (ox <= UNIT_ONE && ox >= -UNIT_ONE &&
      oy <= UNIT_ONE && oy >= -UNIT_ONE && oz <= UNIT_ONE && oz >= -UNIT_ONE))
    else $error("normalized component out of unit range");
`endif

endmodule

FILE: hdl/ttf_back.sv
// ----------------------------------------------------------------------------
// ttf_back
// Frame sequencer: shared multiplier for det, tangent, bitangent and the
// fallback frame, normalizer calls, rounding and the result register.
// ----------------------------------------------------------------------------
module ttf_back import ttf_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   job_valid,
  input  job_t   job_in,
  output logic   pop,
  output logic   frame_valid,
  input  logic   frame_ready,
  output frame_t frame
);

  localparam logic [3:0] B_IDLE   = 4'd0;
  localparam logic [3:0] B_MUL    = 4'd1;
  localparam logic [3:0] B_SIGN   = 4'd2;
  localparam logic [3:0] B_TSTART = 4'd3;
  localparam logic [3:0] B_TWAIT  = 4'd4;
  localparam logic [3:0] B_BSTART = 4'd5;
  localparam logic [3:0] B_BWAIT  = 4'd6;
  localparam logic [3:0] B_ROUND  = 4'd7;
  localparam logic [3:0] B_DONE   = 4'd8;

  localparam logic [4:0] OP_DET0 = 5'd0;
  localparam logic [4:0] OP_DET1 = 5'd1;
  localparam logic [4:0] OP_TX0  = 5'd2;
  localparam logic [4:0] OP_TX1  = 5'd3;
  localparam logic [4:0] OP_TY0  = 5'd4;
  localparam logic [4:0] OP_TY1  = 5'd5;
  localparam logic [4:0] OP_TZ0  = 5'd6;
  localparam logic [4:0] OP_TZ1  = 5'd7;
  localparam logic [4:0] OP_BX0  = 5'd8;
  localparam logic [4:0] OP_BX1  = 5'd9;
  localparam logic [4:0] OP_BY0  = 5'd10;
  localparam logic [4:0] OP_BY1  = 5'd11;
  localparam logic [4:0] OP_BZ0  = 5'd12;
  localparam logic [4:0] OP_BZ1  = 5'd13;
  localparam logic [4:0] OP_FX   = 5'd14;
  localparam logic [4:0] OP_FY   = 5'd15;
  localparam logic [4:0] OP_FZ   = 5'd16;
  localparam logic [4:0] OP_CX0  = 5'd17;
  localparam logic [4:0] OP_CX1  = 5'd18;
  localparam logic [4:0] OP_CY0  = 5'd19;
  localparam logic [4:0] OP_CY1  = 5'd20;
  localparam logic [4:0] OP_CZ0  = 5'd21;
  localparam logic [4:0] OP_CZ1  = 5'd22;

  localparam logic [2:0] ACC_TX  = 3'd0;
  localparam logic [2:0] ACC_TY  = 3'd1;
  localparam logic [2:0] ACC_TZ  = 3'd2;
  localparam logic [2:0] ACC_BX  = 3'd3;
  localparam logic [2:0] ACC_BY  = 3'd4;
  localparam logic [2:0] ACC_BZ  = 3'd5;
  localparam logic [2:0] ACC_DET = 3'd6;
  localparam int N_ACC = 7;

  localparam logic signed [VEC_W-1:0] FB_ONE = VEC_W'(UNIT_ONE) * VEC_W'(UNIT_ONE);
  localparam int RND_HALF = 8192;

  function automatic logic signed [UNIT_W-1:0] round_q28(
    input logic signed [VEC_W-1:0] d);
    logic [VEC_W-1:0] m;
    logic [VEC_W-1:0] q;
    m = d[VEC_W-1] ? VEC_W'(-d) : VEC_W'(d);
    q = (m + VEC_W'(RND_HALF)) >> 14;
    if (q > VEC_W'(UNIT_ONE)) q = VEC_W'(UNIT_ONE);
    round_q28 = d[VEC_W-1] ? -$signed(UNIT_W'(q)) : $signed(UNIT_W'(q));
  endfunction

  logic [3:0]                state, after;
  logic [4:0]                op, op_last;
  logic                      ph, fb;
  job_t                      job;
  logic signed [PROD_W-1:0]  prod;
  logic signed [VEC_W-1:0]   acc [N_ACC];
  logic [STATUS_W-1:0]       status;
  logic signed [UNIT_W-1:0]  tn [3];
  logic signed [UNIT_W-1:0]  bn [3];

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [DUV_W-1:0]   mul_b;
  logic [2:0]                tgt;
  logic                      sub;
  logic signed [VEC_W-1:0]   sprod;

  logic signed [NORM_W:0]    nx_ext;
  logic [NORM_W:0]           nx_mag;
  logic                      axis_y;
  logic signed [NORM_W-1:0]  fb_k;

  logic                      norm_start, sel_b;
  norm_stat_t                nstat;
  logic signed [UNIT_W-1:0]  nox, noy, noz;

  assign pop   = (state == B_IDLE) && job_valid;
  assign sprod = VEC_W'(prod);

  // fallback axis: Y when |n.x| is above the threshold
  assign nx_ext = (NORM_W + 1)'(job.nx);
  assign nx_mag = nx_ext[NORM_W] ? (NORM_W + 1)'(-nx_ext) : (NORM_W + 1)'(nx_ext);
  assign axis_y = nx_mag > (NORM_W + 1)'(job.thr);
  assign fb_k   = axis_y ? job.ny : job.nx;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    tgt   = ACC_DET;
    sub   = 1'b0;
    case (op)
      OP_DET0: begin mul_a = MUL_A_W'(job.du1); mul_b = job.dv2; tgt = ACC_DET; end
      OP_DET1: begin mul_a = MUL_A_W'(job.du2); mul_b = job.dv1; tgt = ACC_DET; sub = 1'b1; end
      OP_TX0:  begin mul_a = MUL_A_W'(job.e1x); mul_b = job.dv2; tgt = ACC_TX; end
      OP_TX1:  begin mul_a = MUL_A_W'(job.e2x); mul_b = job.dv1; tgt = ACC_TX; sub = 1'b1; end
      OP_TY0:  begin mul_a = MUL_A_W'(job.e1y); mul_b = job.dv2; tgt = ACC_TY; end
      OP_TY1:  begin mul_a = MUL_A_W'(job.e2y); mul_b = job.dv1; tgt = ACC_TY; sub = 1'b1; end
      OP_TZ0:  begin mul_a = MUL_A_W'(job.e1z); mul_b = job.dv2; tgt = ACC_TZ; end
      OP_TZ1:  begin mul_a = MUL_A_W'(job.e2z); mul_b = job.dv1; tgt = ACC_TZ; sub = 1'b1; end
      OP_BX0:  begin mul_a = MUL_A_W'(job.e2x); mul_b = job.du1; tgt = ACC_BX; end
      OP_BX1:  begin mul_a = MUL_A_W'(job.e1x); mul_b = job.du2; tgt = ACC_BX; sub = 1'b1; end
      OP_BY0:  begin mul_a = MUL_A_W'(job.e2y); mul_b = job.du1; tgt = ACC_BY; end
      OP_BY1:  begin mul_a = MUL_A_W'(job.e1y); mul_b = job.du2; tgt = ACC_BY; sub = 1'b1; end
      OP_BZ0:  begin mul_a = MUL_A_W'(job.e2z); mul_b = job.du1; tgt = ACC_BZ; end
      OP_BZ1:  begin mul_a = MUL_A_W'(job.e1z); mul_b = job.du2; tgt = ACC_BZ; sub = 1'b1; end
      OP_FX:   begin mul_a = MUL_A_W'(job.nx); mul_b = DUV_W'(fb_k); tgt = ACC_TX; sub = 1'b1; end
      OP_FY:   begin mul_a = MUL_A_W'(job.ny); mul_b = DUV_W'(fb_k); tgt = ACC_TY; sub = 1'b1; end
      OP_FZ:   begin mul_a = MUL_A_W'(job.nz); mul_b = DUV_W'(fb_k); tgt = ACC_TZ; sub = 1'b1; end
      OP_CX0:  begin mul_a = MUL_A_W'(job.ny); mul_b = DUV_W'(tn[2]); tgt = ACC_BX; end
      OP_CX1:  begin mul_a = MUL_A_W'(job.nz); mul_b = DUV_W'(tn[1]); tgt = ACC_BX; sub = 1'b1; end
      OP_CY0:  begin mul_a = MUL_A_W'(job.nz); mul_b = DUV_W'(tn[0]); tgt = ACC_BY; end
      OP_CY1:  begin mul_a = MUL_A_W'(job.nx); mul_b = DUV_W'(tn[2]); tgt = ACC_BY; sub = 1'b1; end
      OP_CZ0:  begin mul_a = MUL_A_W'(job.nx); mul_b = DUV_W'(tn[1]); tgt = ACC_BZ; end
      OP_CZ1:  begin mul_a = MUL_A_W'(job.ny); mul_b = DUV_W'(tn[0]); tgt = ACC_BZ; sub = 1'b1; end
      default: begin mul_a = '0; mul_b = '0; tgt = ACC_DET; sub = 1'b0; end
    endcase
  end

  assign norm_start = (state == B_TSTART) || (state == B_BSTART);
  assign sel_b      = (state == B_BSTART);

  ttf_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (norm_start),
    .cx    (sel_b ? acc[ACC_BX] : acc[ACC_TX]),
    .cy    (sel_b ? acc[ACC_BY] : acc[ACC_TY]),
    .cz    (sel_b ? acc[ACC_BZ] : acc[ACC_TZ]),
    .stat  (nstat),
    .ox    (nox),
    .oy    (noy),
    .oz    (noz)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      frame_valid <= 1'b0;
    end else begin
      // drop the word once taken, unless a new one is loaded this cycle
      if (frame_valid && frame_ready && state != B_DONE) begin
        frame_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (job_valid) begin
            job <= job_in;
            for (int j = 0; j < N_ACC; j++) acc[j] <= '0;
            op      <= OP_DET0;
            op_last <= OP_BZ1;
            after   <= B_SIGN;
            ph      <= 1'b0;
            state   <= B_MUL;
          end
        end
        B_MUL: begin
          if (!ph) begin
            prod <= mul_a * mul_b;
            ph   <= 1'b1;
          end else begin
            ph <= 1'b0;
            for (int j = 0; j < N_ACC; j++) begin
              if (tgt == 3'(j)) begin
                acc[j] <= sub ? acc[j] - sprod : acc[j] + sprod;
              end
            end
            if (op == op_last) begin
              state <= after;
            end else begin
              op <= op + 5'd1;
            end
          end
        end
        B_SIGN: begin
          if (acc[ACC_DET] == '0) begin
            fb          <= 1'b1;
            acc[ACC_TX] <= axis_y ? '0 : FB_ONE;
            acc[ACC_TY] <= axis_y ? FB_ONE : '0;
            acc[ACC_TZ] <= '0;
            op          <= OP_FX;
            op_last     <= OP_FZ;
            after       <= B_TSTART;
            state       <= B_MUL;
          end else begin
            fb <= 1'b0;
            // flip by the sign of det
            if (acc[ACC_DET] < 0) begin
              for (int j = 0; j < 6; j++) acc[j] <= -acc[j];
            end
            state <= B_TSTART;
          end
        end
        B_TSTART: state <= B_TWAIT;
        B_TWAIT: begin
          if (nstat.done) begin
            if (nstat.zero) begin
              status <= ST_ZERO;
              state  <= B_DONE;
            end else begin
              tn[0] <= nox;
              tn[1] <= noy;
              tn[2] <= noz;
              if (fb) begin
                acc[ACC_BX] <= '0;
                acc[ACC_BY] <= '0;
                acc[ACC_BZ] <= '0;
                op          <= OP_CX0;
                op_last     <= OP_CZ1;
                after       <= B_ROUND;
                state       <= B_MUL;
              end else begin
                state <= B_BSTART;
              end
            end
          end
        end
        B_BSTART: state <= B_BWAIT;
        B_BWAIT: begin
          if (nstat.done) begin
            if (nstat.zero) begin
              status <= ST_ZERO;
            end else begin
              bn[0]  <= nox;
              bn[1]  <= noy;
              bn[2]  <= noz;
              status <= ST_NORMAL;
            end
            state <= B_DONE;
          end
        end
        B_ROUND: begin
          bn[0]  <= round_q28(acc[ACC_BX]);
          bn[1]  <= round_q28(acc[ACC_BY]);
          bn[2]  <= round_q28(acc[ACC_BZ]);
          status <= ST_FALLBACK;
          state  <= B_DONE;
        end
        B_DONE: begin
          // hold until the result register is free
          if (!frame_valid || frame_ready) begin
            if (status == ST_ZERO) begin
              frame.tan_x   <= '0;
              frame.tan_y   <= '0;
              frame.tan_z   <= '0;
              frame.bitan_x <= '0;
              frame.bitan_y <= '0;
              frame.bitan_z <= '0;
            end else begin
              frame.tan_x   <= tn[0];
              frame.tan_y   <= tn[1];
              frame.tan_z   <= tn[2];
              frame.bitan_x <= bn[0];
              frame.bitan_y <= bn[1];
              frame.bitan_z <= bn[2];
            end
            frame.frame_status <= status;
            frame_valid        <= 1'b1;
            state              <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule
